FILE: hdl/cht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_pkg
// Types and constants shared by the chained hash table modules.
// ----------------------------------------------------------------------------
package cht_pkg;
  localparam int MaxBuckets  = 16;
  localparam int BucketDepth = 8;
  localparam int BktW   = $clog2(MaxBuckets);
  localparam int SlotW  = $clog2(BucketDepth);
  localparam int FillW  = $clog2(BucketDepth + 1);
  localparam int AddrW  = BktW + SlotW;
  localparam int KeyW   = 31;
  localparam int DataW  = 32;
  localparam int CntW   = 5;
  localparam logic [CntW-1:0] CntReset = CntW'(7);
  localparam logic [CntW-1:0] CntMax   = CntW'(MaxBuckets);

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DELETE = 1'b1;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic [0:0] REG_BUCKET_COUNT = 1'b0;

  typedef struct packed {
    logic             func;
    logic [KeyW-1:0]  key;
    logic [DataW-1:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] bucket;
  } out_item_t;

  typedef struct packed {
    logic            start;
    logic [KeyW-1:0] key;
    logic [CntW-1:0] modulus;
  } mod_req_t;

  typedef struct packed {
    logic            done;
    logic [BktW-1:0] bucket;
  } mod_rsp_t;
endpackage

FILE: hdl/chained_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table
// Hash table with bounded, ordered buckets and separate chaining.
// ----------------------------------------------------------------------------
// Usage: present an operation on in_valid/in_ready (insert or delete by key);
// one transaction comes back on out_valid/out_ready with a status and the
// bucket the key hashed to. The user must write bucket_count at byte
// address 0 of the cfg port only while idle; the block does not enforce it.
// Sequence: the accepting edge starts the bit-serial modulo unit; once it
// is done one step registers the bucket and another reads the fill count,
// after which an insert presents its result. A delete walks the bucket one
// slot at a time (read, compare) and then moves each later entry (read,
// write), plus one closing step, before it presents its result.
// One item is in work at a time; in_ready is low until its result is taken.
// Reset clears all fill counts and sets bucket_count to 7; no clearing pass.
// A stalled receiver holds out_valid and the result stable.
// ----------------------------------------------------------------------------
module chained_hash_table import cht_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_item_t        in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_data,
  input  logic            cfg_psel,
  input  logic            cfg_penable,
  input  logic            cfg_pwrite,
  input  logic [2:0]      cfg_paddr,
  input  logic [31:0]     cfg_pwdata,
  output logic [31:0]     cfg_prdata,
  output logic            cfg_pready
);
  typedef enum logic [2:0] {
    S_IDLE, S_HASH, S_FILL, S_SCAN, S_SHIFT, S_OUT
  } state_t;

  state_t            state_r;
  in_item_t          item_r;
  logic [CntW-1:0]   cnt_r;
  logic [FillW-1:0]  fill_r [MaxBuckets];
  logic [BktW-1:0]   bkt_r;
  logic [FillW-1:0]  cur_fill_r;
  logic [SlotW:0]    idx_r;
  logic              rd_pend_r;
  out_item_t         res_r;
  logic [KeyW-1:0]   key_mem [MaxBuckets*BucketDepth];
  logic [DataW-1:0]  data_mem [MaxBuckets*BucketDepth];
  logic [KeyW-1:0]   rkey_r;
  logic [DataW-1:0]  rdata_r;
  logic [AddrW-1:0]  raddr, waddr;
  logic              we;
  logic [KeyW-1:0]   wkey;
  logic [DataW-1:0]  wdata;
  logic [CntW-1:0]   modulus;
  mod_req_t          mreq;
  mod_rsp_t          mrsp;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_BUCKET_COUNT) ? {27'd0, cnt_r} : 32'd0;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = res_r;

  assign modulus = (cnt_r == '0) ? CntW'(1) : (cnt_r > CntMax) ? CntMax : cnt_r;
  assign mreq.start   = in_valid && in_ready;
  assign mreq.key     = in_data.key;
  assign mreq.modulus = modulus;

  cht_mod u_mod (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  always_comb begin
    raddr = {bkt_r, idx_r[SlotW-1:0]};
    we    = 1'b0;
    waddr = {bkt_r, cur_fill_r[SlotW-1:0]};
    wkey  = item_r.key;
    wdata = item_r.data_value;
    if (state_r == S_FILL && item_r.func == FUNC_INSERT &&
        fill_r[bkt_r] < FillW'(BucketDepth)) begin
      we    = 1'b1;
      waddr = {bkt_r, fill_r[bkt_r][SlotW-1:0]};
    end else if (state_r == S_SHIFT && rd_pend_r) begin
      we    = 1'b1;
      waddr = {bkt_r, idx_r[SlotW-1:0] - 1'b1};
      wkey  = rkey_r;
      wdata = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr]  <= wkey;
      data_mem[waddr] <= wdata;
    end
    rkey_r  <= key_mem[raddr];
    rdata_r <= data_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= CntReset;
      rd_pend_r <= 1'b0;
      bkt_r     <= '0;
      for (int i = 0; i < MaxBuckets; i++) fill_r[i] <= '0;
    end else begin
      if (cfg_wr && cfg_paddr[2] == REG_BUCKET_COUNT) cnt_r <= cfg_pwdata[CntW-1:0];
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            state_r <= S_HASH;
          end
        end
        S_HASH: begin
          if (mrsp.done) begin
            bkt_r   <= mrsp.bucket;
            state_r <= S_FILL;
          end
        end
        S_FILL: begin
          cur_fill_r       <= fill_r[bkt_r];
          idx_r            <= '0;
          rd_pend_r        <= 1'b0;
          res_r.bucket     <= 4'(bkt_r);
          res_r.status     <= ST_DONE;
          if (item_r.func == FUNC_INSERT) begin
            if (fill_r[bkt_r] < FillW'(BucketDepth))
              fill_r[bkt_r] <= fill_r[bkt_r] + 1'b1;
            else
              res_r.status <= ST_FULL;
            state_r <= S_OUT;
          end else if (fill_r[bkt_r] == '0) begin
            res_r.status <= ST_NOT_FOUND;
            state_r      <= S_OUT;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!rd_pend_r) begin
            rd_pend_r <= 1'b1;
          end else begin
            rd_pend_r <= 1'b0;
            if (rkey_r == item_r.key) begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_SHIFT;
            end else if (idx_r + 1'b1 >= (SlotW+1)'(cur_fill_r)) begin
              res_r.status <= ST_NOT_FOUND;
              state_r      <= S_OUT;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        S_SHIFT: begin
          if (idx_r >= (SlotW+1)'(cur_fill_r)) begin
            fill_r[bkt_r] <= cur_fill_r - 1'b1;
            state_r       <= S_OUT;
          end else if (!rd_pend_r) begin
            rd_pend_r <= 1'b1;
          end else begin
            rd_pend_r <= 1'b0;
            idx_r     <= idx_r + 1'b1;
          end
        end
        S_OUT: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[bkt_r] <= FillW'(BucketDepth)) else $error("fill overflow");
  a_full_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && res_r.status == ST_FULL |-> item_r.func == FUNC_INSERT)
    else $error("full on delete");
  a_nf_only_delete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && res_r.status == ST_NOT_FOUND |-> item_r.func == FUNC_DELETE)
    else $error("not found on insert");
  a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, res_r.bucket} < modulus) else $error("bucket range");
endmodule

FILE: hdl/cht_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_mod
// Restoring remainder unit: key modulo bucket count, one bit per cycle.
// ----------------------------------------------------------------------------
module cht_mod import cht_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mod_req_t req,
  output mod_rsp_t rsp
);
  localparam int CW = $clog2(KeyW + 1);
  logic [KeyW-1:0] key_r, key_nxt;
  logic [CntW:0]   rem_r, rem_nxt, shifted;
  logic [CntW-1:0] div_r, div_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    key_nxt  = key_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[CntW-1:0], key_r[KeyW-1]};
    if (req.start) begin
      key_nxt  = req.key;
      rem_nxt  = '0;
      div_nxt  = req.modulus;
      cnt_nxt  = CW'(KeyW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      key_nxt = {key_r[KeyW-2:0], 1'b0};
      rem_nxt = (shifted >= {1'b0, div_r}) ? shifted - {1'b0, div_r} : shifted;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done   = done_r;
  assign rsp.bucket = rem_r[BktW-1:0];

  a_rem_lt_div: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r < {1'b0, div_r}) else $error("remainder not reduced");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start) else $error("start while busy");
endmodule
